/* rtl/core/hrhp_pkg.sv */
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, codes and helpers of the request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    // width of the request target counter
    localparam int COUNT_BITS = 13;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // section codes
    localparam logic [2:0] SECTION_METHOD  = 3'd0;
    localparam logic [2:0] SECTION_TARGET  = 3'd1;
    localparam logic [2:0] SECTION_VERSION = 3'd2;
    localparam logic [2:0] SECTION_KEY     = 3'd3;
    localparam logic [2:0] SECTION_VALUE   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ST_METHOD     = 3'd2;
    localparam logic [2:0] ST_TARGET     = 3'd3;
    localparam logic [2:0] ST_VERSION    = 3'd4;
    localparam logic [2:0] ST_BAD_LINE   = 3'd5;
    localparam logic [2:0] ST_INCOMPLETE = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_METHOD_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_TARGET_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_VERSION_LIMIT = 2'd2;

    // limit values after reset
    localparam logic [3:0]            METHOD_LIMIT_RST  = 4'd8;
    localparam logic [COUNT_BITS-1:0] TARGET_LIMIT_RST  = COUNT_BITS'(4097);
    localparam logic [3:0]            VERSION_LIMIT_RST = 4'd9;

    // characters of interest
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [3:0]            method_limit;
        logic [COUNT_BITS-1:0] target_limit;
        logic [3:0]            version_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] section;
        logic [7:0] char_byte;
        logic       stored;
        logic       token_end;
        logic       drop_previous;
        logic       is_space;
        logic       done_res;
        logic [2:0] status;
    } result_t;

    // tab, LF, CR and printable ASCII
    function automatic logic is_allowed(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
               ((c >= CH_SPACE) && (c <= CH_TILDE));
    endfunction

    // space, tab, CR or LF
    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

/* rtl/core/hrhp_in_stage.sv */
// ----------------------------------------------------------------------------
// hrhp_in_stage
// Input register of the parser: holds one received byte until it is parsed.
// ----------------------------------------------------------------------------
module hrhp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // data_byte
    input  logic               s_tlast,    // last_byte
    input  logic               advance,
    output logic               item_valid,
    output hrhp_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    hrhp_pkg::in_item_t item_reg;

    // room when empty or when the held byte moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

/* rtl/core/hrhp_parse.sv */
// ----------------------------------------------------------------------------
// hrhp_parse
// Parser state and per-byte decision logic: section tracking, length checks,
// header line checks and status.
// ----------------------------------------------------------------------------
module hrhp_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  hrhp_pkg::cfg_t     cfg,
    input  logic               fire,
    input  hrhp_pkg::in_item_t item,
    output logic               res_valid,
    output hrhp_pkg::result_t  res
);

    logic [2:0]                      section_reg,     section_next;
    logic [7:0]                      prev_byte_reg,   prev_byte_next;
    logic [3:0]                      method_cnt_reg,  method_cnt_next;
    logic [hrhp_pkg::COUNT_BITS-1:0] target_cnt_reg,  target_cnt_next;
    logic [3:0]                      version_cnt_reg, version_cnt_next;
    logic [1:0]                      key_len_reg,     key_len_next;
    logic                            key_text_reg,    key_text_next;
    logic                            value_text_reg,  value_text_next;
    logic                            finished_reg,    finished_next;

    logic [7:0] c;
    logic       crlf;
    logic       white;
    logic       stored;
    logic       tend;
    logic       drop;
    logic       done;
    logic [2:0] status;

    assign c     = item.data_byte;
    assign crlf  = (c == hrhp_pkg::CH_LF) && (prev_byte_reg == hrhp_pkg::CH_CR);
    assign white = hrhp_pkg::is_white(c);

    // no result once parsing has finished
    assign res_valid = !finished_reg;

    // per-byte decision
    always_comb
    begin
        section_next     = section_reg;
        prev_byte_next   = c;
        method_cnt_next  = method_cnt_reg;
        target_cnt_next  = target_cnt_reg;
        version_cnt_next = version_cnt_reg;
        key_len_next     = key_len_reg;
        key_text_next    = key_text_reg;
        value_text_next  = value_text_reg;
        stored           = 1'b0;
        tend             = 1'b0;
        drop             = 1'b0;
        done             = 1'b0;
        status           = hrhp_pkg::ST_OK;

        if (!hrhp_pkg::is_allowed(c))
        begin
            done   = 1'b1;
            status = hrhp_pkg::ST_BAD_CHAR;
        end
        else
        begin
            unique case (section_reg)
                hrhp_pkg::SECTION_METHOD:
                begin
                    if (c == hrhp_pkg::CH_SPACE)
                    begin
                        tend         = 1'b1;
                        section_next = hrhp_pkg::SECTION_TARGET;
                    end
                    else if (method_cnt_reg >= cfg.method_limit)
                    begin
                        done   = 1'b1;
                        status = hrhp_pkg::ST_METHOD;
                    end
                    else
                    begin
                        stored          = 1'b1;
                        method_cnt_next = method_cnt_reg + 4'd1;
                    end
                end
                hrhp_pkg::SECTION_TARGET:
                begin
                    if (c == hrhp_pkg::CH_SPACE)
                    begin
                        tend         = 1'b1;
                        section_next = hrhp_pkg::SECTION_VERSION;
                    end
                    else if ((target_cnt_reg >= cfg.target_limit) ||
                             (target_cnt_reg == hrhp_pkg::COUNT_MAX))
                    begin
                        done   = 1'b1;
                        status = hrhp_pkg::ST_TARGET;
                    end
                    else
                    begin
                        stored          = 1'b1;
                        target_cnt_next = target_cnt_reg + 1'b1;
                    end
                end
                hrhp_pkg::SECTION_VERSION:
                begin
                    if (crlf)
                    begin
                        tend         = 1'b1;
                        drop         = 1'b1;
                        section_next = hrhp_pkg::SECTION_KEY;
                    end
                    else if (version_cnt_reg >= cfg.version_limit)
                    begin
                        done   = 1'b1;
                        status = hrhp_pkg::ST_VERSION;
                    end
                    else
                    begin
                        stored           = 1'b1;
                        version_cnt_next = version_cnt_reg + 4'd1;
                    end
                end
                hrhp_pkg::SECTION_KEY:
                begin
                    if (crlf)
                    begin
                        // bare CRLF ends the header, anything else is a bad line
                        tend   = 1'b1;
                        drop   = 1'b1;
                        done   = 1'b1;
                        status = (key_len_reg == 2'd1) ? hrhp_pkg::ST_OK
                                                       : hrhp_pkg::ST_BAD_LINE;
                    end
                    else if (c == hrhp_pkg::CH_COLON)
                    begin
                        tend         = 1'b1;
                        section_next = hrhp_pkg::SECTION_VALUE;
                    end
                    else
                    begin
                        stored = 1'b1;
                        if (key_len_reg != 2'd2)
                        begin
                            key_len_next = key_len_reg + 2'd1;
                        end
                        if (!white)
                        begin
                            key_text_next = 1'b1;
                        end
                    end
                end
                hrhp_pkg::SECTION_VALUE:
                begin
                    if (crlf)
                    begin
                        tend = 1'b1;
                        drop = 1'b1;
                        if (key_text_reg && value_text_reg)
                        begin
                            section_next    = hrhp_pkg::SECTION_KEY;
                            key_len_next    = 2'd0;
                            key_text_next   = 1'b0;
                            value_text_next = 1'b0;
                        end
                        else
                        begin
                            done   = 1'b1;
                            status = hrhp_pkg::ST_BAD_LINE;
                        end
                    end
                    else
                    begin
                        stored = 1'b1;
                        if (!white)
                        begin
                            value_text_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    section_next = section_reg;
                end
            endcase
        end

        // last byte without a finish of its own
        if (!done && item.last_byte)
        begin
            done   = 1'b1;
            status = hrhp_pkg::ST_INCOMPLETE;
        end

        finished_next = finished_reg || done;
    end

    // result fields
    always_comb
    begin
        res.section       = section_reg;
        res.char_byte     = c;
        res.stored        = stored;
        res.token_end     = tend;
        res.drop_previous = drop;
        res.is_space      = white;
        res.done_res      = done;
        res.status        = status;
    end

    // state update, restart after any last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg     <= hrhp_pkg::SECTION_METHOD;
            prev_byte_reg   <= 8'd0;
            method_cnt_reg  <= 4'd0;
            target_cnt_reg  <= '0;
            version_cnt_reg <= 4'd0;
            key_len_reg     <= 2'd0;
            key_text_reg    <= 1'b0;
            value_text_reg  <= 1'b0;
            finished_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                section_reg     <= hrhp_pkg::SECTION_METHOD;
                prev_byte_reg   <= 8'd0;
                method_cnt_reg  <= 4'd0;
                target_cnt_reg  <= '0;
                version_cnt_reg <= 4'd0;
                key_len_reg     <= 2'd0;
                key_text_reg    <= 1'b0;
                value_text_reg  <= 1'b0;
                finished_reg    <= 1'b0;
            end
            else if (!finished_reg)
            begin
                section_reg     <= section_next;
                prev_byte_reg   <= prev_byte_next;
                method_cnt_reg  <= method_cnt_next;
                target_cnt_reg  <= target_cnt_next;
                version_cnt_reg <= version_cnt_next;
                key_len_reg     <= key_len_next;
                key_text_reg    <= key_text_next;
                value_text_reg  <= value_text_next;
                finished_reg    <= finished_next;
            end
        end
    end

endmodule

/* rtl/core/http_request_header_parser.sv */
// ----------------------------------------------------------------------------
// http_request_header_parser
// Tags each request header byte with its section and reports parse status.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle on the slave stream, sustained while
// the master stream does not stall, and presents one tagged result per byte on
// the master stream: the byte waits in the input register, then the decision
// logic writes its result into the output register. The rate is set by the
// section and counter update that each byte makes to the parser state. Once a
// status has been reported, the following bytes produce no result until the
// byte marked with tlast, after which the parser starts a new request. Limits
// are written through the cfg port while the stream is idle.
module http_request_header_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // char_byte, stored, token_end, drop_previous,
                                    // is_space, done_res, status[2:0]
    output logic [2:0]  m_tuser     // section
);

    hrhp_pkg::cfg_t     cfg_reg;
    hrhp_pkg::in_item_t item;
    hrhp_pkg::result_t  res;
    hrhp_pkg::result_t  out_reg;
    logic               item_valid;
    logic               res_valid;
    logic               out_free;
    logic               fire;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = item_valid && out_free;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method_limit  <= hrhp_pkg::METHOD_LIMIT_RST;
            cfg_reg.target_limit  <= hrhp_pkg::TARGET_LIMIT_RST;
            cfg_reg.version_limit <= hrhp_pkg::VERSION_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hrhp_pkg::CFG_METHOD_LIMIT:  cfg_reg.method_limit  <= cfg_data[3:0];
                hrhp_pkg::CFG_TARGET_LIMIT:  cfg_reg.target_limit  <= cfg_data;
                hrhp_pkg::CFG_VERSION_LIMIT: cfg_reg.version_limit <= cfg_data[3:0];
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    hrhp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    hrhp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.section;
    assign m_tdata  = {out_reg.status, out_reg.done_res, out_reg.is_space,
                       out_reg.drop_previous, out_reg.token_end, out_reg.stored,
                       out_reg.char_byte};

`ifndef ASSERT_OFF
    // status is only nonzero on the result that finishes parsing
    a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[12]) |-> (m_tdata[15:13] == hrhp_pkg::ST_OK))
        else $error("status set on a result that is not done");

    // removing the previous CR only happens when a token or line closes
    a_drop_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[10]) |-> m_tdata[9])
        else $error("drop_previous without token_end");

    // a byte is never both stored and a token terminator
    a_store_excludes_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> !m_tdata[9])
        else $error("stored byte also closes token");

    // a last byte taken while parsing always reports a finish
    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && item.last_byte) |=> (m_tvalid && m_tdata[12]))
        else $error("last byte did not finish parsing");
`endif

endmodule

/* tb/sv/http_request_header_parser_tb.sv */
// ----------------------------------------------------------------------------
// http_request_header_parser_tb
// Self-checking bench for the request header parser. Byte streams are built
// from well-formed requests with random content, damaged requests and raw
// noise, and pushed through the slave stream under random gaps. Each accepted
// byte is run through a local copy of the parser to predict its tag, and
// tagged results on the master stream are compared against those predictions
// in order. Limits are rewritten between phases, lowest and highest included.
// ----------------------------------------------------------------------------
module http_request_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_METHOD_LIMIT;
    logic [12:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // data_byte
    logic        s_tlast   = 1'b0;  // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // char_byte, stored, token_end, drop_previous,
                                    // is_space, done_res, status[2:0]
    logic [2:0]  m_tuser;           // section

    // limits as the parser holds them
    logic [3:0]            lim_method  = METHOD_LIMIT_RST;
    logic [COUNT_BITS-1:0] lim_target  = TARGET_LIMIT_RST;
    logic [3:0]            lim_version = VERSION_LIMIT_RST;

    // parse state of the local copy
    logic [2:0]            sec_now     = SECTION_METHOD;
    logic [7:0]            prev_ch     = '0;
    logic [3:0]            method_cnt  = '0;
    logic [COUNT_BITS-1:0] target_cnt  = '0;
    logic [3:0]            version_cnt = '0;
    logic [1:0]            key_len     = '0;
    logic                  key_text    = 1'b0;
    logic                  value_text  = 1'b0;
    logic                  halted      = 1'b0;

    in_item_t byte_q[$];
    in_item_t next_item;
    result_t  expected_tags[$];
    result_t  seen;
    result_t  want;

    int snd_idle_pct = 8;
    int rcv_idle_pct = 60;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    http_request_header_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // back to the start of a request
    function automatic void restart_parse();
        sec_now     = SECTION_METHOD;
        prev_ch     = '0;
        method_cnt  = '0;
        target_cnt  = '0;
        version_cnt = '0;
        key_len     = '0;
        key_text    = 1'b0;
        value_text  = 1'b0;
        halted      = 1'b0;
    endfunction

    // tag one accepted byte and queue the result it produces, if any
    function automatic void tag_byte(input logic [7:0] c, input logic last);
        result_t r;
        logic    crlf;
        logic    ws;
        logic    legal;
        if (halted)
        begin
            if (last)
                restart_parse();
            return;
        end
        crlf  = (c == CH_LF) && (prev_ch == CH_CR);
        ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        legal = (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
                ((c >= CH_SPACE) && (c <= CH_TILDE));
        r           = '0;
        r.section   = sec_now;
        r.char_byte = c;
        r.is_space  = ws;
        if (!legal)
        begin
            r.done_res = 1'b1;
            r.status   = ST_BAD_CHAR;
        end
        else
        begin
            case (sec_now)
                SECTION_METHOD:
                begin
                    if (c == CH_SPACE)
                    begin
                        r.token_end = 1'b1;
                        sec_now     = SECTION_TARGET;
                    end
                    else if (method_cnt >= lim_method)
                    begin
                        r.done_res = 1'b1;
                        r.status   = ST_METHOD;
                    end
                    else
                    begin
                        r.stored   = 1'b1;
                        method_cnt = method_cnt + 4'd1;
                    end
                end
                SECTION_TARGET:
                begin
                    if (c == CH_SPACE)
                    begin
                        r.token_end = 1'b1;
                        sec_now     = SECTION_VERSION;
                    end
                    else if (target_cnt >= lim_target || target_cnt >= COUNT_MAX)
                    begin
                        r.done_res = 1'b1;
                        r.status   = ST_TARGET;
                    end
                    else
                    begin
                        r.stored   = 1'b1;
                        target_cnt = target_cnt + 1'b1;
                    end
                end
                SECTION_VERSION:
                begin
                    if (crlf)
                    begin
                        r.token_end     = 1'b1;
                        r.drop_previous = 1'b1;
                        sec_now         = SECTION_KEY;
                    end
                    else if (version_cnt >= lim_version)
                    begin
                        r.done_res = 1'b1;
                        r.status   = ST_VERSION;
                    end
                    else
                    begin
                        r.stored    = 1'b1;
                        version_cnt = version_cnt + 4'd1;
                    end
                end
                SECTION_KEY:
                begin
                    if (crlf)
                    begin
                        // a lone CR before the LF marks the end of the header
                        r.token_end     = 1'b1;
                        r.drop_previous = 1'b1;
                        r.done_res      = 1'b1;
                        r.status        = (key_len == 2'd1) ? ST_OK : ST_BAD_LINE;
                    end
                    else if (c == CH_COLON)
                    begin
                        r.token_end = 1'b1;
                        sec_now     = SECTION_VALUE;
                    end
                    else
                    begin
                        r.stored = 1'b1;
                        if (key_len < 2'd2)
                            key_len = key_len + 2'd1;
                        if (!ws)
                            key_text = 1'b1;
                    end
                end
                default:
                begin
                    if (crlf)
                    begin
                        r.token_end     = 1'b1;
                        r.drop_previous = 1'b1;
                        if (key_text && value_text)
                        begin
                            sec_now    = SECTION_KEY;
                            key_len    = '0;
                            key_text   = 1'b0;
                            value_text = 1'b0;
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            r.status   = ST_BAD_LINE;
                        end
                    end
                    else
                    begin
                        r.stored = 1'b1;
                        if (!ws)
                            value_text = 1'b1;
                    end
                end
            endcase
        end
        prev_ch = c;
        if (!r.done_res && last)
        begin
            r.done_res = 1'b1;
            r.status   = ST_INCOMPLETE;
        end
        if (r.done_res)
            halted = 1'b1;
        expected_tags.push_back(r);
        if (last)
            restart_parse();
    endfunction

    function automatic string fmt_tag(input result_t t);
        return $sformatf("sec=%0d ch=%02h st=%0b end=%0b drop=%0b ws=%0b done=%0b status=%0d",
                         t.section, t.char_byte, t.stored, t.token_end, t.drop_previous,
                         t.is_space, t.done_res, t.status);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        byte_q.push_back(it);
    endfunction

    function automatic void push_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], last_at_end && (i == s.len() - 1));
    endfunction

    // printable, no space and no colon
    function automatic logic [7:0] tok_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        return (c == CH_COLON) ? 8'h41 : c;
    endfunction

    // header value text, with some whitespace and stray line bytes
    function automatic logic [7:0] text_char();
        int unsigned pick;
        pick = $urandom_range(31);
        if (pick == 0)
            return CH_TAB;
        if (pick == 1)
            return CH_LF;
        if (pick == 2)
            return CH_CR;
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // token length: mostly within the limit, sometimes empty or one over
    function automatic int unsigned token_len(input int unsigned limit, input int unsigned cap);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8 && limit < cap)
            return limit + 1;
        if (r < 12 || limit == 0)
            return $urandom_range(0, 1);
        return $urandom_range(1, (limit < cap) ? limit : cap);
    endfunction

    // one request: request line, header lines, blank line, then an ending
    function automatic void queue_request();
        logic [7:0]  req[$];
        int unsigned n;
        int unsigned r;
        int unsigned cut;
        int unsigned lines;
        repeat (token_len(lim_method, 16))
            req.push_back(tok_char());
        req.push_back(CH_SPACE);
        repeat (token_len(lim_target, 24))
            req.push_back(tok_char());
        req.push_back(CH_SPACE);
        // the CR counts toward the version length
        n = token_len(lim_version, 16);
        repeat ((n > 0) ? n - 1 : 0)
            req.push_back(tok_char());
        req.push_back(CH_CR);
        req.push_back(CH_LF);
        lines = $urandom_range(0, 4);
        for (int h = 0; h < lines; h++)
        begin
            r = $urandom_range(99);
            if (r >= 4 && r < 7)
                req.push_back(CH_SPACE);
            else if (r >= 7)
                repeat ($urandom_range(1, 6))
                    req.push_back(tok_char());
            if (r >= 7 && r < 10)
            begin
                // key line with no colon
                req.push_back(CH_CR);
                req.push_back(CH_LF);
                continue;
            end
            req.push_back(CH_COLON);
            r = $urandom_range(99);
            if (r < 50)
                req.push_back(CH_SPACE);
            if (r >= 5)
                repeat ($urandom_range(1, 8))
                    req.push_back(text_char());
            req.push_back(CH_CR);
            req.push_back(CH_LF);
        end
        req.push_back(CH_CR);
        req.push_back(CH_LF);
        if ($urandom_range(99) < 15)
            req[$urandom_range(req.size() - 1)] = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 20)
        begin
            cut = $urandom_range(1, req.size());
            req = req[0:cut-1];
        end
        else if (r < 40)
        begin
            repeat ($urandom_range(1, 5))
                req.push_back(8'($urandom_range(255)));
        end
        for (int i = 0; i < req.size(); i++)
            push_byte(req[i], i == req.size() - 1);
    endfunction

    // raw bytes, random last flags, always closed by a last
    function automatic void queue_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(255)), ($urandom_range(4) == 0) || (i == n - 1));
    endfunction

    function automatic void queue_random(input int unsigned count);
        int unsigned goal;
        goal = byte_q.size() + count;
        while (byte_q.size() < goal)
        begin
            if ($urandom_range(9) == 0)
                queue_noise();
            else
                queue_request();
        end
    endfunction

    // write all three limits, junk above the 4-bit fields
    task automatic write_limits(input logic [3:0] m, input logic [12:0] t, input logic [3:0] v);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_index   <= CFG_METHOD_LIMIT;
        cfg_data    <= {9'($urandom), m};
        lim_method  <= m;
        @(posedge clk);
        cfg_index   <= CFG_TARGET_LIMIT;
        cfg_data    <= t;
        lim_target  <= t;
        @(posedge clk);
        cfg_index   <= CFG_VERSION_LIMIT;
        cfg_data    <= {9'($urandom), v};
        lim_version <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        @(negedge clk);
    endtask

    // sender paused until every predicted tag is back and the parser is quiet
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || s_tvalid || expected_tags.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // slave side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                tag_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    next_item = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data_byte;
                    s_tlast  <= next_item.last_byte;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // master side monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.section       = m_tuser;
                seen.char_byte     = m_tdata[7:0];
                seen.stored        = m_tdata[8];
                seen.token_end     = m_tdata[9];
                seen.drop_previous = m_tdata[10];
                seen.is_space      = m_tdata[11];
                seen.done_res      = m_tdata[12];
                seen.status        = m_tdata[15:13];
                if (expected_tags.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", fmt_tag(seen));
                end
                else
                begin
                    want = expected_tags.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tag mismatch\n  expected %s\n  actual   %s",
                                     fmt_tag(want), fmt_tag(seen));
                    end
                end
            end
            // long hold-off on request, else random stalls
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_done != hold_reqs)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAIL http_request_header_parser");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // stimulus phases
    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: clean request, bad bytes, bare LF, incomplete, bad key line
        push_text("G / H\r\n\r\n", 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_text("~\n", 1'b1);
        push_byte(8'h7F, 1'b1);
        push_text("G / H\r\nx\r\n", 1'b1);
        queue_random(120);
        wait_drained();

        // limits of one
        write_limits(4'd1, 13'd1, 4'd1);
        queue_random(100);
        wait_drained();

        // largest limits
        snd_idle_pct = 60;
        rcv_idle_pct = 8;
        write_limits(4'd15, COUNT_MAX, 4'd15);
        queue_random(120);
        wait_drained();

        // zero limits
        write_limits(4'd0, 13'd0, 4'd0);
        queue_random(40);
        wait_drained();

        // random limits, no idling, one long receiver hold-off
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_limits(4'($urandom_range(1, 15)), 13'($urandom_range(1, 40)),
                     4'($urandom_range(2, 15)));
        queue_random(200);
        hold_reqs++;
        wait_drained();

        write_limits(4'($urandom_range(1, 15)), 13'($urandom_range(1, 40)),
                     4'($urandom_range(2, 15)));
        queue_random(170);
        wait_drained();

        if (mismatches == 0 && expected_tags.size() == 0)
            $display("PASS http_request_header_parser");
        else
            $display("FAIL http_request_header_parser");
        $finish;
    end

endmodule
